FILE: src/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

   // Fixed field widths of the item channels
   localparam int SITE_W  = 20;
   localparam int TYPE_W  = 7;
   localparam int ROT_W   = 18;
   localparam int POS_W   = 16;
   localparam int COUNT_W = 9;
   localparam int TOL_W   = 15;

   // Tolerance after reset, about 0.01 at 16 fraction bits
   localparam logic [TOL_W-1:0] TOL_RESET = 15'd655;

   // Rotation entry codes; anything else acts as zero
   localparam logic [1:0] ROT_PLUS  = 2'b01;
   localparam logic [1:0] ROT_MINUS = 2'b11;

   typedef logic [TYPE_W-1:0] kind_type;

endpackage

`default_nettype wire

FILE: src/sed_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item: one site plus one symmetry operation
interface sed_req_if;
   logic                 valid;
   logic                 ready;
   logic                 new_structure;
   logic signed [19:0]   site_x;
   logic signed [19:0]   site_y;
   logic signed [19:0]   site_z;
   logic [6:0]           atom_type;
   logic [17:0]          rotation;
   logic signed [19:0]   shift_x;
   logic signed [19:0]   shift_y;
   logic signed [19:0]   shift_z;

   modport source (output valid, new_structure, site_x, site_y, site_z, atom_type,
                   rotation, shift_x, shift_y, shift_z, input ready);
   modport sink   (input valid, new_structure, site_x, site_y, site_z, atom_type,
                   rotation, shift_x, shift_y, shift_z, output ready);
endinterface

// Result item
interface sed_rsp_if;
   logic          valid;
   logic          ready;
   logic [15:0]   pos_x;
   logic [15:0]   pos_y;
   logic [15:0]   pos_z;
   logic          is_new;
   logic          overflow;
   logic [8:0]    unique_count;

   modport source (output valid, pos_x, pos_y, pos_z, is_new, overflow, unique_count,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, is_new, overflow, unique_count,
                   output ready);
endinterface

// Tolerance register write
interface sed_csr_if;
   logic          valid;
   logic          ready;
   logic [14:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/sed_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic compare of one stored entry against the new position
module sed_match #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic [FRAC_BITS-1:0]     pos_x,
   input  wire logic [FRAC_BITS-1:0]     pos_y,
   input  wire logic [FRAC_BITS-1:0]     pos_z,
   input  wire sed_pkg::kind_type        kind,
   input  wire logic [FRAC_BITS-1:0]     ent_x,
   input  wire logic [FRAC_BITS-1:0]     ent_y,
   input  wire logic [FRAC_BITS-1:0]     ent_z,
   input  wire sed_pkg::kind_type        ent_kind,
   input  wire logic [sed_pkg::TOL_W-1:0] tol,
   output logic                          hit
);
   import sed_pkg::*;

   localparam int DW = FRAC_BITS + 1;
   localparam int CW = (DW > TOL_W) ? DW : TOL_W;
   localparam logic [DW-1:0] ONE_FX  = DW'(1) << FRAC_BITS;
   localparam logic [DW-1:0] HALF_FX = DW'(1) << (FRAC_BITS - 1);

   // Minimum-image distance on one axis, checked against the tolerance
   function automatic logic axis_close(input logic [FRAC_BITS-1:0] a,
                                       input logic [FRAC_BITS-1:0] b,
                                       input logic [TOL_W-1:0] t);
      logic [DW-1:0] d;
      logic [DW-1:0] dm;
      d  = (a >= b) ? DW'(a - b) : DW'(b - a);
      dm = (d > HALF_FX) ? (ONE_FX - d) : d;
      return CW'(dm) < CW'(t);
   endfunction

   assign hit = (kind == ent_kind) &&
                axis_close(pos_x, ent_x, tol) &&
                axis_close(pos_y, ent_y, tol) &&
                axis_close(pos_z, ent_z, tol);

endmodule

`default_nettype wire

FILE: src/symmetry_expand_dedup.sv
`timescale 1ns / 1ps
`default_nettype none

// Symmetry expansion with periodic duplicate removal. Each input item is one
// atom site and one symmetry operation; the block forms R*p + t, wraps each
// coordinate to [0,1) and scans its table of unique atoms, one stored entry per
// cycle through a single read port and a single periodic compare unit. An item
// passes through the transform (one axis per cycle), the scan of the stored
// entries (all of them on a miss, fewer when a match stops the scan), a commit
// of the result and a return to idle, where the next item is taken. The commit
// waits for as long as the output register still holds a result that has not
// been taken. The block takes no new item while one is at work; a finished
// result waits in the output register while the next item is accepted. A write
// to the tolerance register is taken at any time but should only be issued
// while the block is idle. No clearing pass is needed after reset: entries
// above the fill count are never read.
module symmetry_expand_dedup #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sed_req_if.sink     req,
   sed_rsp_if.source   rsp,
   sed_csr_if.sink     csr
);
   import sed_pkg::*;

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ACC_W = (FRAC_BITS > SITE_W) ? FRAC_BITS : SITE_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XFORM,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] x;
      logic [FRAC_BITS-1:0] y;
      logic [FRAC_BITS-1:0] z;
      kind_type             kind;
   } entry_type;

   state_type                state_ff;
   logic [1:0]               axis_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         addr_ff;
   logic                     rd_vld_ff;
   logic                     found_ff;
   logic [TOL_W-1:0]         tol_ff;

   // Latched item
   logic signed [SITE_W-1:0] site_x_ff, site_y_ff, site_z_ff;
   logic signed [SITE_W-1:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [ROT_W-1:0]         rotation_ff;
   kind_type                 kind_ff;
   logic [FRAC_BITS-1:0]     pos_ff [3];

   // Result register
   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                     rsp_new_ff;
   logic                     rsp_ovf_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   // Table memory
   entry_type                table_mem [TABLE_DEPTH];
   entry_type                rd_data_ff;
   logic                     mem_re;
   logic                     mem_we;

   logic                     hit;
   logic                     scan_end;
   logic                     slot_free;
   logic                     room;
   logic [5:0]               rot_row;
   logic signed [SITE_W-1:0] shift_sel;
   logic signed [ACC_W-1:0]  acc;

   // Signed contribution of one matrix entry
   function automatic logic signed [ACC_W-1:0] term(input logic [1:0] code,
                                                    input logic signed [SITE_W-1:0] v);
      logic signed [ACC_W-1:0] ve;
      ve = ACC_W'(v);
      case (code)
         ROT_PLUS:  return ve;
         ROT_MINUS: return -ve;
         default:   return '0;
      endcase
   endfunction

   // Transform: one output axis per cycle
   always_comb begin
      case (axis_ff)
         2'd0:    begin rot_row = rotation_ff[5:0];   shift_sel = shift_x_ff; end
         2'd1:    begin rot_row = rotation_ff[11:6];  shift_sel = shift_y_ff; end
         default: begin rot_row = rotation_ff[17:12]; shift_sel = shift_z_ff; end
      endcase
      acc = ACC_W'(shift_sel) + term(rot_row[1:0], site_x_ff)
          + term(rot_row[3:2], site_y_ff) + term(rot_row[5:4], site_z_ff);
   end

   // Compare unit on the registered table read
   sed_match #(
      .FRAC_BITS (FRAC_BITS)
   ) u_match (
      .pos_x    (pos_ff[0]),
      .pos_y    (pos_ff[1]),
      .pos_z    (pos_ff[2]),
      .kind     (kind_ff),
      .ent_x    (rd_data_ff.x),
      .ent_y    (rd_data_ff.y),
      .ent_z    (rd_data_ff.z),
      .ent_kind (rd_data_ff.kind),
      .tol      (tol_ff),
      .hit      (hit)
   );

   // Scan control
   assign scan_end  = (state_ff == ST_SCAN) && ((rd_vld_ff && hit) || (addr_ff == count_ff));
   assign mem_re    = (state_ff == ST_SCAN) && !scan_end;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign room      = count_ff < DEPTH_CNT;
   assign mem_we    = (state_ff == ST_DONE) && slot_free && !found_ff && room;

   // Table memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[AW-1:0]] <= '{x: pos_ff[0], y: pos_ff[1], z: pos_ff[2],
                                          kind: kind_ff};
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[addr_ff[AW-1:0]];
      end
   end

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr.valid) begin
         tol_ff <= csr.data;
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         count_ff     <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drain the output unless a new result loads in the same cycle
         if (rsp_valid_ff && rsp.ready && !(state_ff == ST_DONE && slot_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  site_x_ff   <= req.site_x;
                  site_y_ff   <= req.site_y;
                  site_z_ff   <= req.site_z;
                  shift_x_ff  <= req.shift_x;
                  shift_y_ff  <= req.shift_y;
                  shift_z_ff  <= req.shift_z;
                  rotation_ff <= req.rotation;
                  kind_ff     <= req.atom_type;
                  if (req.new_structure) begin
                     count_ff <= '0;
                  end
                  axis_ff  <= 2'd0;
                  state_ff <= ST_XFORM;
               end
            end
            ST_XFORM: begin
               pos_ff[axis_ff] <= acc[FRAC_BITS-1:0];
               axis_ff         <= axis_ff + 2'd1;
               if (axis_ff == 2'd2) begin
                  addr_ff   <= '0;
                  rd_vld_ff <= 1'b0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= mem_re;
               if (mem_re) begin
                  addr_ff <= addr_ff + CNT_W'(1);
               end
               if (scan_end) begin
                  found_ff <= rd_vld_ff && hit;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= POS_W'(pos_ff[0]);
                  rsp_y_ff     <= POS_W'(pos_ff[1]);
                  rsp_z_ff     <= POS_W'(pos_ff[2]);
                  rsp_new_ff   <= !found_ff && room;
                  rsp_ovf_ff   <= !found_ff && !room;
                  if (!found_ff && room) begin
                     count_ff     <= count_ff + CNT_W'(1);
                     rsp_count_ff <= COUNT_W'(count_ff + CNT_W'(1));
                  end else begin
                     rsp_count_ff <= COUNT_W'(count_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Ports
   assign req.ready        = (state_ff == ST_IDLE);
   assign csr.ready        = 1'b1;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pos_x        = rsp_x_ff;
   assign rsp.pos_y        = rsp_y_ff;
   assign rsp.pos_z        = rsp_z_ff;
   assign rsp.is_new       = rsp_new_ff;
   assign rsp.overflow     = rsp_ovf_ff;
   assign rsp.unique_count = rsp_count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above table depth");

   a_new_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_ovf_ff))
      else $error("result both new and overflow");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_XFORM))
      else $error("accepted item did not start transform");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_valid_ff)
      else $error("stored entry not counted");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read outstanding outside scan");

endmodule

`default_nettype wire
